// File: rtl/core/buzzer_beep_sequencer_unit_defines.svh
// Assertion macros shared by the sequencer RTL.
`ifndef BUZZER_BEEP_SEQUENCER_UNIT_DEFINES_SVH
`define BUZZER_BEEP_SEQUENCER_UNIT_DEFINES_SVH

// Concurrent check on the rising edge of clk, ignored while rst is high.
`define BBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, but also evaluated during reset.
`define BBS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/bbs_pkg.sv
package bbs_pkg;

  localparam int TIME_BITS_DEF = 16;
  localparam int FREQ_BITS_DEF = 16;
  localparam int DUTY_BITS_DEF = 8;

  localparam int ADDR_BITS = 3;
  localparam logic [ADDR_BITS-1:0] REG_ENABLED_ADDR = 3'd0;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_TONE   = 3'd1;
  localparam logic [2:0] MODE_BEEP   = 3'd2;
  localparam logic [2:0] MODE_STOP   = 3'd3;
  localparam logic [2:0] MODE_PRESET = 3'd4;

  localparam logic [2:0] PRESET_OK       = 3'd0;
  localparam logic [2:0] PRESET_CLICK    = 3'd1;
  localparam logic [2:0] PRESET_WARN     = 3'd2;
  localparam logic [2:0] PRESET_ERROR    = 3'd3;
  localparam logic [2:0] PRESET_SHUTDOWN = 3'd4;

  typedef struct packed {
    logic        known;
    logic [7:0]  count;
    logic [15:0] freq;
    logic [15:0] on_ms;
    logic [15:0] gap_ms;
  } preset_t;

  typedef struct packed {
    logic        tone_on;
    logic [15:0] tone_freq;
    logic [7:0]  pwm_duty;
    logic        sequence_active;
    logic        rejected;
  } result_t;

  function automatic preset_t preset_lookup(input logic [2:0] id);
    preset_t p;
    p = '0;
    unique case (id)
      PRESET_OK:       p = '{1'b1, 8'd1, 16'd4000, 16'd120, 16'd0};
      PRESET_CLICK:    p = '{1'b1, 8'd1, 16'd6000, 16'd20,  16'd0};
      PRESET_WARN:     p = '{1'b1, 8'd2, 16'd2500, 16'd100, 16'd100};
      PRESET_ERROR:    p = '{1'b1, 8'd3, 16'd1500, 16'd150, 16'd100};
      PRESET_SHUTDOWN: p = '{1'b1, 8'd1, 16'd800,  16'd400, 16'd0};
      default:         p = '0;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/core/buzzer_beep_sequencer_unit.sv
// Buzzer beep sequencer.
// Input channel (in_valid/in_stall) carries one command transaction per item:
// a one-millisecond tick, tone, beep, stop or preset. Every accepted item
// yields exactly one result transaction on the output channel
// (out_valid/out_stall) showing the buzzer state after the item is applied,
// plus a rejected flag for ignored commands.
// The state update and the result are computed in the cycle of acceptance
// and the result is registered. Throughput is one item per cycle while
// in_stall is low, set by the single state register stage.
// A two-entry output buffer (output register plus skid register) lets the
// block take an item while the previous result still waits. When the
// receiver stalls, one more item is taken into the skid register and then
// in_stall rises until the output register drains.
// The APB port holds the enable register at address 0; while it is 0 every
// item is answered with rejected set and the state is left untouched.
// Synchronous reset clears all state, both buffer entries and the enable.
`include "buzzer_beep_sequencer_unit_defines.svh"

module buzzer_beep_sequencer_unit
  import bbs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int FREQ_BITS = FREQ_BITS_DEF,
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           mode,
  input  logic [15:0]          freq_in,
  input  logic [15:0]          on_time,
  input  logic [15:0]          gap_time,
  input  logic [7:0]           beep_count,
  input  logic [2:0]           preset_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 tone_on,
  output logic [15:0]          tone_freq,
  output logic [7:0]           pwm_duty,
  output logic                 sequence_active,
  output logic                 rejected
);

  localparam logic [32:0] FREQ_MAX = (33'd1 << FREQ_BITS) - 33'd1;
  localparam logic [32:0] TIME_MAX = (33'd1 << TIME_BITS) - 33'd1;
  localparam logic [7:0]  DUTY_HALF = (DUTY_BITS > 8) ? 8'd255 : 8'(1 << (DUTY_BITS - 1));
  localparam logic [TIME_BITS-1:0] TIME_ONE = {{(TIME_BITS-1){1'b0}}, 1'b1};

  // Configuration.
  logic enabled;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_ENABLED_ADDR);
  assign prdata    = (paddr == REG_ENABLED_ADDR) ? {31'd0, enabled} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (cfg_write) begin
      enabled <= pwdata[0];
    end
  end

  // Sequencer state.
  logic                 sounding, sounding_next;
  logic [FREQ_BITS-1:0] sound_freq, sound_freq_next;
  logic [7:0]           beeps_left, beeps_left_next;
  logic                 in_on_phase, in_on_phase_next;
  logic [TIME_BITS-1:0] phase_countdown, phase_countdown_next;
  logic                 stop_armed, stop_armed_next;
  logic [TIME_BITS-1:0] stop_countdown, stop_countdown_next;
  logic [TIME_BITS-1:0] on_time_hold, on_time_hold_next;
  logic [TIME_BITS-1:0] gap_time_hold, gap_time_hold_next;
  logic                 rejected_next;

  // Handshake.
  logic    accept, pop;
  logic    skid_valid;
  result_t out_res, skid_res, new_res;

  assign accept   = in_valid && !skid_valid;
  assign pop      = out_valid && !out_stall;
  assign in_stall = skid_valid;

  // Sources for starting a beep sequence, from the command or a preset.
  preset_t              preset;
  logic                 is_preset;
  logic [7:0]           src_count;
  logic [32:0]          src_freq, src_on, src_gap, tone_on_wide;
  logic [FREQ_BITS-1:0] src_freq_sat;
  logic [TIME_BITS-1:0] src_on_sat, src_gap_sat, tone_time_sat;
  logic [TIME_BITS-1:0] stop_dec, phase_dec;
  logic [31:0]          freq_wide;

  always_comb begin
    preset    = preset_lookup(preset_id);
    is_preset = (mode == MODE_PRESET);
    src_count = is_preset ? preset.count : beep_count;
    src_freq  = 33'(is_preset ? preset.freq   : freq_in);
    src_on    = 33'(is_preset ? preset.on_ms  : on_time);
    src_gap   = 33'(is_preset ? preset.gap_ms : gap_time);
    src_freq_sat = (src_freq > FREQ_MAX) ? FREQ_MAX[FREQ_BITS-1:0] : src_freq[FREQ_BITS-1:0];
    src_on_sat   = (src_on   > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : src_on[TIME_BITS-1:0];
    src_gap_sat  = (src_gap  > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : src_gap[TIME_BITS-1:0];
    tone_on_wide  = 33'(on_time);
    tone_time_sat = (tone_on_wide > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0]
                                              : tone_on_wide[TIME_BITS-1:0];
    stop_dec  = (stop_countdown  != '0) ? stop_countdown  - TIME_ONE : stop_countdown;
    phase_dec = (phase_countdown != '0) ? phase_countdown - TIME_ONE : phase_countdown;
  end

  always_comb begin
    sounding_next        = sounding;
    sound_freq_next      = sound_freq;
    beeps_left_next      = beeps_left;
    in_on_phase_next     = in_on_phase;
    phase_countdown_next = phase_countdown;
    stop_armed_next      = stop_armed;
    stop_countdown_next  = stop_countdown;
    on_time_hold_next    = on_time_hold;
    gap_time_hold_next   = gap_time_hold;
    rejected_next        = 1'b0;

    if (!enabled) begin
      rejected_next = 1'b1;
    end else begin
      unique case (mode) inside
        MODE_TICK: begin
          // The single-shot stop is handled before the sequence.
          if (stop_armed) begin
            stop_countdown_next = stop_dec;
            if (stop_dec == '0) begin
              stop_armed_next = 1'b0;
              sounding_next   = 1'b0;
            end
          end
          if (beeps_left != 8'd0) begin
            phase_countdown_next = phase_dec;
            if (phase_dec == '0) begin
              if (in_on_phase) begin
                sounding_next   = 1'b0;
                beeps_left_next = beeps_left - 8'd1;
                if (beeps_left != 8'd1) begin
                  in_on_phase_next     = 1'b0;
                  phase_countdown_next = gap_time_hold;
                end
              end else begin
                sounding_next        = (sound_freq != '0);
                in_on_phase_next     = 1'b1;
                phase_countdown_next = on_time_hold;
              end
            end
          end
        end
        MODE_TONE: begin
          beeps_left_next     = 8'd0;
          sound_freq_next     = src_freq_sat;
          sounding_next       = (src_freq_sat != '0);
          stop_countdown_next = tone_time_sat;
          stop_armed_next     = (on_time != 16'd0);
        end
        MODE_BEEP, MODE_PRESET: begin
          if ((is_preset && !preset.known) || (!is_preset && beep_count == 8'd0)) begin
            rejected_next = 1'b1;
          end else begin
            beeps_left_next      = src_count;
            sound_freq_next      = src_freq_sat;
            on_time_hold_next    = src_on_sat;
            gap_time_hold_next   = src_gap_sat;
            in_on_phase_next     = 1'b1;
            phase_countdown_next = src_on_sat;
            stop_armed_next      = 1'b0;
            sounding_next        = (src_freq_sat != '0);
          end
        end
        MODE_STOP: begin
          beeps_left_next = 8'd0;
          stop_armed_next = 1'b0;
          sounding_next   = 1'b0;
        end
        default: begin
          rejected_next = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    freq_wide               = 32'(sound_freq_next);
    new_res.tone_on         = sounding_next;
    new_res.tone_freq       = sounding_next ? freq_wide[15:0] : 16'd0;
    new_res.pwm_duty        = sounding_next ? DUTY_HALF : 8'd0;
    new_res.sequence_active = (beeps_left_next != 8'd0);
    new_res.rejected        = rejected_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sounding        <= 1'b0;
      sound_freq      <= '0;
      beeps_left      <= 8'd0;
      in_on_phase     <= 1'b0;
      phase_countdown <= '0;
      stop_armed      <= 1'b0;
      stop_countdown  <= '0;
      on_time_hold    <= '0;
      gap_time_hold   <= '0;
    end else if (accept) begin
      sounding        <= sounding_next;
      sound_freq      <= sound_freq_next;
      beeps_left      <= beeps_left_next;
      in_on_phase     <= in_on_phase_next;
      phase_countdown <= phase_countdown_next;
      stop_armed      <= stop_armed_next;
      stop_countdown  <= stop_countdown_next;
      on_time_hold    <= on_time_hold_next;
      gap_time_hold   <= gap_time_hold_next;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_res <= skid_valid ? skid_res : new_res;
    end else if (accept) begin
      skid_res <= new_res;
    end
  end

  assign tone_on         = out_res.tone_on;
  assign tone_freq       = out_res.tone_freq;
  assign pwm_duty        = out_res.pwm_duty;
  assign sequence_active = out_res.sequence_active;
  assign rejected        = out_res.rejected;

  `BBS_ASSERT(a_skid_behind_out, skid_valid |-> out_valid,
              "skid entry held without output entry")
  `BBS_ASSERT(a_stop_xor_seq, !(stop_armed && beeps_left != 8'd0),
              "stop armed during a sequence")
  `BBS_ASSERT(a_sound_freq, sounding |-> (sound_freq != '0), "sounding at zero frequency")
  `BBS_ASSERT(a_disabled_hold, (accept && !enabled) |=>
              ($stable(sounding) && $stable(beeps_left) &&
               $stable(phase_countdown) && $stable(stop_countdown)),
              "state changed while disabled")
  `BBS_ASSERT(a_silent_out, (out_valid && !tone_on) |->
              (tone_freq == 16'd0 && pwm_duty == 8'd0),
              "silent result carries a tone")

endmodule

// File: sim/bbs_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the APB port, keeps its own copy of the buzzer
// state and compares every result transaction against the oldest prediction.
module bbs_checker
  import bbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [2:0]           mode,
  input  logic [15:0]          freq_in,
  input  logic [15:0]          on_time,
  input  logic [15:0]          gap_time,
  input  logic [7:0]           beep_count,
  input  logic [2:0]           preset_id,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 tone_on,
  input  logic [15:0]          tone_freq,
  input  logic [7:0]           pwm_duty,
  input  logic                 sequence_active,
  input  logic                 rejected,
  output int                   fail_count,
  output int                   pending,
  output int                   checked
);

  localparam logic [7:0] HALF_DUTY = 8'(1 << (DUTY_BITS_DEF - 1));

  logic        enabled;
  logic        buzz_on;
  logic [15:0] buzz_freq;
  logic [7:0]  beeps_left;
  logic        on_phase;
  logic [15:0] phase_cnt;
  logic        stop_armed;
  logic [15:0] stop_cnt;
  logic [15:0] on_hold;
  logic [15:0] gap_hold;

  result_t buzzer_states_due[$];

  task automatic start_sequence(input logic [7:0] cnt, input logic [15:0] f,
                                input logic [15:0] on_ms, input logic [15:0] gap_ms);
    beeps_left = cnt;
    buzz_freq  = f;
    on_hold    = on_ms;
    gap_hold   = gap_ms;
    on_phase   = 1'b1;
    phase_cnt  = on_ms;
    stop_armed = 1'b0;
    buzz_on    = (f != 16'd0);
  endtask

  // The single-shot stop is serviced before the beep sequence on each tick.
  task automatic advance_ms();
    if (stop_armed) begin
      if (stop_cnt != 16'd0) stop_cnt = stop_cnt - 16'd1;
      if (stop_cnt == 16'd0) begin
        stop_armed = 1'b0;
        buzz_on    = 1'b0;
      end
    end
    if (beeps_left != 8'd0) begin
      if (phase_cnt != 16'd0) phase_cnt = phase_cnt - 16'd1;
      if (phase_cnt == 16'd0) begin
        if (on_phase) begin
          buzz_on    = 1'b0;
          beeps_left = beeps_left - 8'd1;
          if (beeps_left != 8'd0) begin
            on_phase  = 1'b0;
            phase_cnt = gap_hold;
          end
        end else begin
          buzz_on   = (buzz_freq != 16'd0);
          on_phase  = 1'b1;
          phase_cnt = on_hold;
        end
      end
    end
  endtask

  task automatic predict_buzzer(input logic [2:0] m, input logic [15:0] f,
                                input logic [15:0] on_ms, input logic [15:0] gap_ms,
                                input logic [7:0] cnt, input logic [2:0] pid,
                                output result_t r);
    logic refused;
    refused = 1'b0;
    if (!enabled) begin
      refused = 1'b1;
    end else begin
      case (m)
        MODE_TICK: advance_ms();
        MODE_TONE: begin
          beeps_left = 8'd0;
          buzz_freq  = f;
          buzz_on    = (f != 16'd0);
          stop_cnt   = on_ms;
          stop_armed = (on_ms != 16'd0);
        end
        MODE_BEEP: begin
          if (cnt == 8'd0) refused = 1'b1;
          else start_sequence(cnt, f, on_ms, gap_ms);
        end
        MODE_STOP: begin
          beeps_left = 8'd0;
          stop_armed = 1'b0;
          buzz_on    = 1'b0;
        end
        MODE_PRESET: begin
          case (pid)
            PRESET_OK:       start_sequence(8'd1, 16'd4000, 16'd120, 16'd0);
            PRESET_CLICK:    start_sequence(8'd1, 16'd6000, 16'd20, 16'd0);
            PRESET_WARN:     start_sequence(8'd2, 16'd2500, 16'd100, 16'd100);
            PRESET_ERROR:    start_sequence(8'd3, 16'd1500, 16'd150, 16'd100);
            PRESET_SHUTDOWN: start_sequence(8'd1, 16'd800, 16'd400, 16'd0);
            default:         refused = 1'b1;
          endcase
        end
        default: refused = 1'b1;
      endcase
    end
    r.tone_on         = buzz_on;
    r.tone_freq       = buzz_on ? buzz_freq : 16'd0;
    r.pwm_duty        = buzz_on ? HALF_DUTY : 8'd0;
    r.sequence_active = (beeps_left != 8'd0);
    r.rejected        = refused;
  endtask

  always @(posedge clk) begin
    result_t due;
    if (rst) begin
      enabled    = 1'b0;
      buzz_on    = 1'b0;
      buzz_freq  = '0;
      beeps_left = '0;
      on_phase   = 1'b0;
      phase_cnt  = '0;
      stop_armed = 1'b0;
      stop_cnt   = '0;
      on_hold    = '0;
      gap_hold   = '0;
      fail_count = 0;
      checked    = 0;
      buzzer_states_due.delete();
    end else begin
      // Retire the older result first: a command accepted at this edge
      // cannot have produced the result leaving at this edge.
      if (out_valid && !out_stall) begin
        if (buzzer_states_due.size() == 0) begin
          $error("result transaction with no command outstanding");
          fail_count++;
        end else begin
          due = buzzer_states_due.pop_front();
          checked++;
          if (due.tone_on !== tone_on) begin
            $error("tone_on: expected %0d, got %0d", due.tone_on, tone_on);
            fail_count++;
          end
          if (due.tone_freq !== tone_freq) begin
            $error("tone_freq: expected %0d, got %0d", due.tone_freq, tone_freq);
            fail_count++;
          end
          if (due.pwm_duty !== pwm_duty) begin
            $error("pwm_duty: expected %0d, got %0d", due.pwm_duty, pwm_duty);
            fail_count++;
          end
          if (due.sequence_active !== sequence_active) begin
            $error("sequence_active: expected %0d, got %0d",
                   due.sequence_active, sequence_active);
            fail_count++;
          end
          if (due.rejected !== rejected) begin
            $error("rejected: expected %0d, got %0d", due.rejected, rejected);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_buzzer(mode, freq_in, on_time, gap_time, beep_count, preset_id, due);
        buzzer_states_due.push_back(due);
      end
      if (psel && penable && pwrite && pready && paddr == REG_ENABLED_ADDR)
        enabled = pwdata[0];
    end
    pending <= buzzer_states_due.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bbs_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           mode;
  logic [15:0]          freq_in;
  logic [15:0]          on_time;
  logic [15:0]          gap_time;
  logic [7:0]           beep_count;
  logic [2:0]           preset_id;
  logic                 out_valid;
  logic                 out_stall;
  logic                 tone_on;
  logic [15:0]          tone_freq;
  logic [7:0]           pwm_duty;
  logic                 sequence_active;
  logic                 rejected;
  int                   fail_count;
  int                   pending;
  int                   checked;

  int sent_total;
  int enable_writes;
  int burst_left;

  buzzer_beep_sequencer_unit dut (.*);
  bbs_checker checker_i (.*);

  always #1 clk = ~clk;

  task automatic send_item(input logic [2:0] m, input logic [15:0] f,
                           input logic [15:0] on_ms, input logic [15:0] gap_ms,
                           input logic [7:0] cnt, input logic [2:0] pid);
    int gap;
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        burst_left = $urandom_range(20, 80);
        gap = 0;
      end else if (pick < 50) gap = 0;
      else if (pick < 85) gap = $urandom_range(1, 3);
      else if (pick < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode       <= m;
    freq_in    <= f;
    on_time    <= on_ms;
    gap_time   <= gap_ms;
    beep_count <= cnt;
    preset_id  <= pid;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_total++;
  endtask

  task automatic tick();
    send_item(MODE_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
              8'($urandom), 3'($urandom));
  endtask

  // Drops valid and waits until every result transaction has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ENABLED_ADDR;
    pwdata  <= {31'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    enable_writes++;
  endtask

  function automatic logic [15:0] pick_ms();
    case ($urandom_range(0, 19))
      0:       return 16'($urandom);
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 6));
    endcase
  endfunction

  // Mostly a command with random content followed by a run of ticks long
  // enough to let its deadlines expire; unknown codes are mixed in as noise.
  task automatic random_phase(input int n_items);
    int          sent;
    int          kind;
    int          ticks;
    logic [15:0] f;
    logic [7:0]  cnt;
    logic [2:0]  pid;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      f    = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
      case ($urandom_range(0, 14))
        0:       cnt = 8'd0;
        1:       cnt = 8'($urandom);
        default: cnt = 8'($urandom_range(1, 4));
      endcase
      pid = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
      if (kind < 35) send_item(MODE_TONE, f, pick_ms(), 16'($urandom), cnt, pid);
      else if (kind < 65) send_item(MODE_BEEP, f, pick_ms(), pick_ms(), cnt, pid);
      else if (kind < 75) send_item(MODE_STOP, f, 16'($urandom), 16'($urandom), cnt, pid);
      else if (kind < 92) send_item(MODE_PRESET, f, 16'($urandom), 16'($urandom), cnt, pid);
      else send_item(3'($urandom_range(5, 7)), f, pick_ms(), pick_ms(), cnt, pid);
      sent++;
      ticks = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 420) : $urandom_range(0, 6);
      for (int i = 0; i < ticks && sent < n_items; i++) begin
        tick();
        sent++;
      end
    end
  endtask

  initial begin
    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid   <= 1'b0;
    mode       <= MODE_TICK;
    freq_in    <= '0;
    on_time    <= '0;
    gap_time   <= '0;
    beep_count <= '0;
    preset_id  <= '0;
    sent_total    = 0;
    enable_writes = 0;
    burst_left    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Disabled block: everything is refused and the state stays put.
    write_enable(1'b0);
    send_item(MODE_TONE, 16'd1000, 16'd0, 16'd0, 8'd0, PRESET_OK);
    send_item(MODE_TICK, '0, '0, '0, '0, '0);
    wait_idle();
    write_enable(1'b1);

    send_item(MODE_TONE, 16'hFFFF, 16'd0, 16'd0, 8'd0, PRESET_OK);
    send_item(MODE_TICK, '0, '0, '0, '0, '0);
    // Silent tone still runs its stop timer.
    send_item(MODE_TONE, 16'd0, 16'd2, 16'd0, 8'd0, PRESET_OK);
    send_item(MODE_TICK, '0, '0, '0, '0, '0);
    send_item(MODE_TICK, '0, '0, '0, '0, '0);
    send_item(MODE_TONE, 16'd1234, 16'd1, 16'd0, 8'd0, PRESET_OK);
    send_item(MODE_TICK, '0, '0, '0, '0, '0);
    send_item(MODE_BEEP, 16'd900, 16'd5, 16'd5, 8'd0, PRESET_OK);
    // Silent beeps keep their on and gap timing.
    send_item(MODE_BEEP, 16'd0, 16'd1, 16'd1, 8'd2, PRESET_OK);
    repeat (3) send_item(MODE_TICK, '0, '0, '0, '0, '0);
    // A beep disarms the pending stop, and a tone cancels the sequence.
    send_item(MODE_TONE, 16'd700, 16'd3, 16'd0, 8'd0, PRESET_OK);
    send_item(MODE_BEEP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, PRESET_OK);
    send_item(MODE_TICK, '0, '0, '0, '0, '0);
    send_item(MODE_TONE, 16'd300, 16'd0, 16'd0, 8'd0, PRESET_OK);
    send_item(MODE_STOP, '0, '0, '0, '0, '0);
    for (int p = 0; p < 8; p++) send_item(MODE_PRESET, '0, '0, '0, '0, 3'(p));
    for (int m = 5; m < 8; m++) send_item(3'(m), 16'd500, 16'd1, 16'd1, 8'd1, PRESET_OK);
    wait_idle();

    random_phase(900);
    wait_idle();
    write_enable(1'b0);
    random_phase(120);
    wait_idle();
    write_enable(1'b1);
    random_phase(850);
    wait_idle();
    repeat (8) @(posedge clk);

    $display("Sent %0d command and tick transactions over enabled, disabled and",
             sent_total);
    $display("re-enabled phases (%0d enable writes); %0d results compared.",
             enable_writes, checked);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Receiver: short random stalls, free-running stretches, and long hold-offs
  // that fill the output buffer and push back on the sender.
  initial begin
    int  hold;
    int  roll;
    int  n_cyc;
    bit  long_done;
    n_cyc     = 0;
    long_done = 1'b0;
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      roll = $urandom_range(0, 59);
      if ((!long_done && n_cyc > 400 && in_valid) || roll == 0) begin
        hold      = $urandom_range(120, 250);
        long_done = 1'b1;
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        n_cyc += hold;
      end else if (roll < 8) begin
        hold = $urandom_range(20, 80);
        out_stall <= 1'b0;
        repeat (hold) @(posedge clk);
        n_cyc += hold;
      end else if (roll < 14) begin
        hold = $urandom_range(2, 8);
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        n_cyc += hold;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        @(posedge clk);
        n_cyc++;
      end
    end
  end

  initial begin
    #6000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/bbs_pkg.sv
rtl/core/buzzer_beep_sequencer_unit.sv
sim/bbs_checker.sv
sim/tb_top.sv
